[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Define ASSERT_OFF to drop
// every check from a build. The macros expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// check at every clock edge outside reset
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hdl/pbe_pkg.sv]
// ----------------------------------------------------------------------------
// pbe_pkg
// Shared types and constants of the packed base editor: command codes,
// field widths and default sizes of the word store.
// ----------------------------------------------------------------------------
package pbe_pkg;

  // default store geometry
  localparam int unsigned STORE_WORDS_DEF    = 1024;
  localparam int unsigned BASES_PER_WORD_DEF = 32;

  // fixed field widths
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned BASE_W  = 2;
  localparam int unsigned POS_W   = 15;
  localparam int unsigned WIDX_W  = 10;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned NUM_BASES = 4;

  // command codes; code 3 is unused and yields an all-zero result
  typedef enum logic [1:0] {
    CMD_LOAD_WORD  = 2'd0,
    CMD_EDIT_BASE  = 2'd1,
    CMD_LOAD_COUNT = 2'd2
  } cmd_t;

endpackage

[hdl/pbe_word_ram.sv]
// ----------------------------------------------------------------------------
// pbe_word_ram
// Simple dual-port word store: one write port and one read port with
// registered read data (a read returns the old contents on a same-cycle
// write).
// ----------------------------------------------------------------------------
module pbe_word_ram #(
  parameter int unsigned DEPTH = pbe_pkg::STORE_WORDS_DEF,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = pbe_pkg::WORD_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/packed_base_editor_with_counts_unit.sv]
// ----------------------------------------------------------------------------
// packed_base_editor_with_counts_unit
// Word store of packed two-bit bases with four base counters; edits one base
// per item and keeps the counters in step.
// ----------------------------------------------------------------------------
// The unit sustains one item per cycle while the result channel is not
// stalled; an accepted item passes the work stage and then the result
// register. An edit item reads its store word in the cycle it is accepted
// (synchronous RAM); in the work stage the old base is extracted, the word
// is rewritten through the single write port, the counters update and the
// result is registered. A back-to-back edit to the same word takes the
// just-written word from a forwarding register, so the read-modify-write
// loop through the RAM port does not limit the rate. Word and counter loads
// pass through the same two stages. The store has no reset: edit only words
// that were loaded first. Counters clear on reset. Out-of-range addresses
// and the unused command give an all-zero result and change nothing.
module packed_base_editor_with_counts_unit #(
  parameter int unsigned STORE_WORDS    = pbe_pkg::STORE_WORDS_DEF,
  parameter int unsigned BASES_PER_WORD = pbe_pkg::BASES_PER_WORD_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_cmd,
  input  logic [pbe_pkg::POS_W-1:0]        in_position,
  input  logic [pbe_pkg::BASE_W-1:0]       in_new_base,
  input  logic [pbe_pkg::WIDX_W-1:0]       in_word_index,
  input  logic [pbe_pkg::WORD_W-1:0]       in_word_data,
  input  logic [pbe_pkg::COUNT_W-1:0]      in_count_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pbe_pkg::BASE_W-1:0]       out_old_base,
  output logic [pbe_pkg::WORD_W-1:0]       out_word_after,
  output logic [pbe_pkg::COUNT_W-1:0]      out_old_base_count,
  output logic [pbe_pkg::COUNT_W-1:0]      out_new_base_count
);

  `include "assert_macros.svh"

  localparam int unsigned AW     = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned CMP_W  = 21;
  localparam int unsigned RW     = $clog2(BASES_PER_WORD);
  // exact quotient by a constant: q = (pos * DIV_M) >> DIV_SH
  localparam int unsigned DIV_SH = 21;
  localparam int unsigned DIV_M  = ((1 << DIV_SH) + BASES_PER_WORD - 1) / BASES_PER_WORD;
  localparam int unsigned PROD_W = pbe_pkg::POS_W + DIV_SH;

  localparam int unsigned WW = pbe_pkg::WORD_W;
  localparam int unsigned CW = pbe_pkg::COUNT_W;
  localparam int unsigned BW = pbe_pkg::BASE_W;
  localparam int unsigned PW = pbe_pkg::POS_W;

  // handshake
  logic in_acc;
  logic p1_go;

  // input side address computation
  logic [PROD_W-1:0] div_prod;
  logic [PW-1:0]     in_q;
  logic              in_ok;
  logic [AW-1:0]     in_addr;

  // work stage
  logic              p1_vld_r, p1_vld_nxt;
  pbe_pkg::cmd_t     p1_cmd_r;
  logic              p1_ok_r;
  logic [AW-1:0]     p1_addr_r;
  logic [PW-1:0]     p1_pos_r;
  logic [PW-1:0]     p1_q_r;
  logic [BW-1:0]     p1_nb_r;
  logic [WW-1:0]     p1_wdata_r;
  logic [CW-1:0]     p1_cval_r;

  // last write, for forwarding
  logic              lw_vld_r;
  logic [AW-1:0]     lw_addr_r;
  logic [WW-1:0]     lw_data_r;

  // store port
  logic              ram_we;
  logic [WW-1:0]     ram_wdata;
  logic [WW-1:0]     ram_rdata;

  // edit datapath
  logic [WW-1:0]     cur_word;
  logic [PW-1:0]     rem_full;
  logic [RW-1:0]     rem;
  logic [pbe_pkg::SHIFT_W-1:0] shift;
  logic [BW-1:0]     old_base;
  logic [WW-1:0]     mask;
  logic [WW-1:0]     new_word;
  logic              edit_go;

  // counters
  logic [pbe_pkg::NUM_BASES-1:0][CW-1:0] cnt_r, cnt_nxt;
  logic [pbe_pkg::NUM_BASES-1:0][CW-1:0] cnt_edit;

  // result register
  logic              out_vld_r, out_vld_nxt;
  logic [BW-1:0]     out_ob_r, res_ob_nxt;
  logic [WW-1:0]     out_word_r, res_word_nxt;
  logic [CW-1:0]     out_oc_r, res_oc_nxt;
  logic [CW-1:0]     out_nc_r, res_nc_nxt;

  // handshake: the work stage advances when the result register is free
  assign p1_go    = p1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = p1_vld_r && !p1_go;
  assign in_acc   = in_valid && !in_stall;

  // word index and range check of the incoming item
  assign div_prod = PROD_W'(in_position) * PROD_W'(DIV_M);
  assign in_q     = div_prod[PROD_W-1 -: PW];

  always_comb begin
    in_ok   = 1'b0;
    in_addr = '0;
    if (in_cmd == pbe_pkg::CMD_EDIT_BASE) begin
      in_ok   = CMP_W'(in_q) < CMP_W'(STORE_WORDS);
      in_addr = AW'(in_q);
    end else begin
      in_ok   = CMP_W'(in_word_index) < CMP_W'(STORE_WORDS);
      in_addr = AW'(in_word_index);
    end
  end

  // work stage valid
  always_comb begin
    p1_vld_nxt = p1_vld_r;
    if (in_acc) begin
      p1_vld_nxt = 1'b1;
    end else if (p1_go) begin
      p1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= p1_vld_nxt;
    end
  end

  // capture the item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_cmd_r   <= pbe_pkg::cmd_t'(in_cmd);
      p1_ok_r    <= in_ok;
      p1_addr_r  <= in_addr;
      p1_pos_r   <= in_position;
      p1_q_r     <= in_q;
      p1_nb_r    <= in_new_base;
      p1_wdata_r <= in_word_data;
      p1_cval_r  <= in_count_value;
    end
  end

  pbe_word_ram #(
    .DEPTH (STORE_WORDS),
    .AW    (AW),
    .DW    (WW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p1_addr_r),
    .wdata (ram_wdata),
    .re    (in_acc && (in_cmd == pbe_pkg::CMD_EDIT_BASE) && in_ok),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // forward the word written at the edge of the read
  assign cur_word = (lw_vld_r && (lw_addr_r == p1_addr_r)) ? lw_data_r : ram_rdata;

  // base slot within the word, first base in the top pair
  assign rem_full = p1_pos_r - PW'(p1_q_r * PW'(BASES_PER_WORD));
  assign rem      = rem_full[RW-1:0];
  assign shift    = pbe_pkg::SHIFT_W'(2 * (BASES_PER_WORD - 1))
                  - pbe_pkg::SHIFT_W'({rem, 1'b0});
  assign old_base = BW'(cur_word >> shift);
  assign mask     = WW'(3) << shift;
  assign new_word = (cur_word & ~mask) | (WW'(p1_nb_r) << shift);

  // counters after the edit: drop the old base, add the new one
  always_comb begin
    for (int i = 0; i < pbe_pkg::NUM_BASES; i++) begin
      cnt_edit[i] = cnt_r[i] - CW'(BW'(i) == old_base) + CW'(BW'(i) == p1_nb_r);
    end
  end

  // decode the command, build write, counter update and result
  always_comb begin
    ram_we       = 1'b0;
    ram_wdata    = p1_wdata_r;
    cnt_nxt      = cnt_r;
    res_ob_nxt   = '0;
    res_word_nxt = '0;
    res_oc_nxt   = '0;
    res_nc_nxt   = '0;
    unique case (p1_cmd_r)
      pbe_pkg::CMD_LOAD_WORD: begin
        if (p1_ok_r) begin
          ram_we       = p1_go;
          ram_wdata    = p1_wdata_r;
          res_word_nxt = p1_wdata_r;
        end
      end
      pbe_pkg::CMD_EDIT_BASE: begin
        if (p1_ok_r) begin
          ram_we       = p1_go;
          ram_wdata    = new_word;
          cnt_nxt      = cnt_edit;
          res_ob_nxt   = old_base;
          res_word_nxt = new_word;
          res_oc_nxt   = cnt_edit[old_base];
          res_nc_nxt   = cnt_edit[p1_nb_r];
        end
      end
      pbe_pkg::CMD_LOAD_COUNT: begin
        cnt_nxt[p1_nb_r] = p1_cval_r;
        res_oc_nxt       = p1_cval_r;
        res_nc_nxt       = p1_cval_r;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // counters advance with the work stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (p1_go) begin
      cnt_r <= cnt_nxt;
    end
  end

  // remember the last store write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_vld_r <= 1'b0;
    end else if (ram_we) begin
      lw_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      lw_addr_r <= p1_addr_r;
      lw_data_r <= ram_wdata;
    end
  end

  // result register: fill on advance, drop when taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (p1_go) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_go) begin
      out_ob_r   <= res_ob_nxt;
      out_word_r <= res_word_nxt;
      out_oc_r   <= res_oc_nxt;
      out_nc_r   <= res_nc_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_old_base       = out_ob_r;
  assign out_word_after     = out_word_r;
  assign out_old_base_count = out_oc_r;
  assign out_new_base_count = out_nc_r;

  // edit in range leaving the work stage
  assign edit_go = p1_go && p1_ok_r && (p1_cmd_r == pbe_pkg::CMD_EDIT_BASE);

  // checks
  `ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_vld_r, "result valid after reset")
  `ASSERT_CLKD(a_write_on_advance, ram_we |-> p1_go, "store write without stage advance")
  `ASSERT_CLKD(a_accept_fills_stage, in_acc |=> p1_vld_r, "accepted item lost")
  `ASSERT_CLKD(a_edit_keeps_other_bases,
               edit_go |-> (((new_word ^ cur_word) & ~mask) == '0),
               "edit touched another base")
  `ASSERT_CLKD(a_same_base_keeps_counts,
               (edit_go && old_base == p1_nb_r) |=> $stable(cnt_r),
               "counts moved on equal bases")

endmodule
